>>> hdl/mau_pkg.sv
// shared types and codes for the modular arithmetic unit
package mau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4
    } op_t;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_RED_A    = 15'b000000000000010,
        S_RED_B    = 15'b000000000000100,
        S_DISP     = 15'b000000000001000,
        S_ADD      = 15'b000000000010000,
        S_SUB      = 15'b000000000100000,
        S_MUL_DBL  = 15'b000000001000000,
        S_MUL_ADD  = 15'b000000010000000,
        S_POW_CHK  = 15'b000000100000000,
        S_POW_ACC  = 15'b000001000000000,
        S_POW_BASE = 15'b000010000000000,
        S_EUC_CHK  = 15'b000100000000000,
        S_EUC_DIV  = 15'b001000000000000,
        S_EUC_UPD  = 15'b010000000000000,
        S_FIN      = 15'b100000000000000
    } state_t;

endpackage

>>> hdl/mau_div.sv
// iterative restoring divider, one quotient bit per cycle
module mau_div
    import mau_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CW'(W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

>>> hdl/modular_arithmetic_unit.sv
// top level of the modular arithmetic unit: sequencer, modular adder and divider
//
// usage
//   a transaction is taken when start is high and busy is low; req_type,
//   operand_a and operand_b are sampled then. busy stays high until the result
//   is out. the result appears on result and no_inverse for exactly one cycle
//   with done high; the receiver cannot hold it off.
//   modulus is written when modulus_we is high; the user must raise modulus_we
//   only while busy is low, since the block itself does not enforce it.
//   unless the modulus is zero (result zero), both operands pass through the
//   shared restoring divider and dispatch. add and subtract then pass once
//   through the modular adder. a modular multiply runs through the shared
//   modular adder. power runs one squaring per exponent bit up to the highest
//   set bit and one multiply per set bit. divide runs one divider pass and one
//   multiply per euclid step, plus a final multiply when an inverse exists.
//   one transaction at a time; the next can be taken in the strobe cycle.
// reset
//   modulus returns to 1, the block is idle and done is low.
module modular_arithmetic_unit
    import mau_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic        modulus_we,
    input  logic [31:0] modulus,
    output logic        done,
    output logic [31:0] result,
    output logic        no_inverse
);

    localparam int W  = WORD_WIDTH;
    localparam int IW = (W < 32) ? W : 32;
    localparam int CW = $clog2(W);

    state_t        state_reg, state_next;
    state_t        ret_reg, ret_next;
    logic [W-1:0]  m_reg, m_next;
    logic [2:0]    op_reg, op_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  p_reg, p_next;
    logic [W-1:0]  mx_reg, mx_next;
    logic [W-1:0]  my_reg, my_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  r0_reg, r0_next;
    logic [W-1:0]  r1_reg, r1_next;
    logic [W-1:0]  t0_reg, t0_next;
    logic [W-1:0]  t1_reg, t1_next;
    logic [31:0]   result_reg, result_next;
    logic          noinv_reg, noinv_next;
    logic          done_reg, done_next;

    logic          div_start;
    logic [W-1:0]  div_num;
    logic [W-1:0]  div_den;
    logic          div_done;
    logic [W-1:0]  div_quo;
    logic [W-1:0]  div_rem;

    logic [W-1:0]  am_x;
    logic [W-1:0]  am_y;
    logic [W:0]    am_sum;
    logic [W:0]    am_red;
    logic [W-1:0]  am_out;
    logic [W-1:0]  neg_in;
    logic [W-1:0]  neg_out;
    logic [W-1:0]  q_mod;

    mau_div #(.W(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // shared modular adder
    assign neg_out = (neg_in == '0) ? '0 : (m_reg - neg_in);
    assign am_sum  = {1'b0, am_x} + {1'b0, am_y};
    assign am_red  = am_sum - {1'b0, m_reg};
    assign am_out  = (am_sum >= {1'b0, m_reg}) ? am_red[W-1:0] : am_sum[W-1:0];
    assign q_mod   = (div_quo >= m_reg) ? (div_quo - m_reg) : div_quo;

    always_comb
    begin
        neg_in = (state_reg == S_SUB) ? b_reg : p_reg;
        am_x   = p_reg;
        am_y   = p_reg;
        case (state_reg)
            S_ADD:
            begin
                am_x = a_reg;
                am_y = b_reg;
            end
            S_SUB:
            begin
                am_x = a_reg;
                am_y = neg_out;
            end
            S_MUL_ADD:
            begin
                am_x = p_reg;
                am_y = mx_reg;
            end
            S_EUC_UPD:
            begin
                am_x = t0_reg;
                am_y = neg_out;
            end
            default:
            begin
                am_x = p_reg;
                am_y = p_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        m_next      = m_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        p_next      = p_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        cnt_next    = cnt_reg;
        r0_next     = r0_reg;
        r1_next     = r1_reg;
        t0_next     = t0_reg;
        t1_next     = t1_reg;
        result_next = result_reg;
        noinv_next  = noinv_reg;
        done_next   = 1'b0;
        div_start   = 1'b0;
        div_num     = W'(operand_a[IW-1:0]);
        div_den     = m_reg;

        if (modulus_we)
        begin
            m_next = W'(modulus[IW-1:0]);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = req_type;
                    b_next  = W'(operand_b[IW-1:0]);
                    if (m_reg == '0)
                    begin
                        p_next     = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_RED_A;
                    end
                end
            end
            S_RED_A:
            begin
                div_num = b_reg;
                if (div_done)
                begin
                    a_next     = div_rem;
                    div_start  = 1'b1;
                    state_next = S_RED_B;
                end
            end
            S_RED_B:
            begin
                if (div_done)
                begin
                    b_next     = div_rem;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                mx_next  = a_reg;
                my_next  = b_reg;
                p_next   = '0;
                cnt_next = CW'(W - 1);
                case (op_reg)
                    OP_ADD: state_next = S_ADD;
                    OP_SUB: state_next = S_SUB;
                    OP_MUL:
                    begin
                        ret_next   = S_FIN;
                        state_next = S_MUL_DBL;
                    end
                    OP_DIV:
                    begin
                        if (m_reg == W'(1))
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            r0_next    = m_reg;
                            r1_next    = b_reg;
                            t0_next    = '0;
                            t1_next    = W'(1);
                            state_next = S_EUC_CHK;
                        end
                    end
                    OP_POW:
                    begin
                        acc_next   = (m_reg == W'(1)) ? '0 : W'(1);
                        state_next = S_POW_CHK;
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_ADD, S_SUB:
            begin
                p_next     = am_out;
                state_next = S_FIN;
            end
            S_MUL_DBL:
            begin
                p_next = am_out;
                if (my_reg[cnt_reg])
                begin
                    state_next = S_MUL_ADD;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_MUL_ADD:
            begin
                p_next = am_out;
                if (cnt_reg == '0)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_MUL_DBL;
                end
            end
            S_POW_CHK:
            begin
                p_next   = '0;
                cnt_next = CW'(W - 1);
                if (b_reg == '0)
                begin
                    p_next     = acc_reg;
                    state_next = S_FIN;
                end
                else if (b_reg[0])
                begin
                    mx_next    = acc_reg;
                    my_next    = a_reg;
                    ret_next   = S_POW_ACC;
                    state_next = S_MUL_DBL;
                end
                else
                begin
                    mx_next    = a_reg;
                    my_next    = a_reg;
                    ret_next   = S_POW_BASE;
                    state_next = S_MUL_DBL;
                end
            end
            S_POW_ACC:
            begin
                acc_next   = p_reg;
                p_next     = '0;
                cnt_next   = CW'(W - 1);
                mx_next    = a_reg;
                my_next    = a_reg;
                ret_next   = S_POW_BASE;
                state_next = S_MUL_DBL;
            end
            S_POW_BASE:
            begin
                a_next     = p_reg;
                b_next     = b_reg >> 1;
                state_next = S_POW_CHK;
            end
            S_EUC_CHK:
            begin
                p_next   = '0;
                cnt_next = CW'(W - 1);
                div_num  = r0_reg;
                div_den  = r1_reg;
                if (r1_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_EUC_DIV;
                end
                else if (r0_reg == W'(1))
                begin
                    mx_next    = a_reg;
                    my_next    = t0_reg;
                    ret_next   = S_FIN;
                    state_next = S_MUL_DBL;
                end
                else
                begin
                    result_next = '0;
                    noinv_next  = 1'b1;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_EUC_DIV:
            begin
                if (div_done)
                begin
                    mx_next    = q_mod;
                    my_next    = t1_reg;
                    ret_next   = S_EUC_UPD;
                    state_next = S_MUL_DBL;
                end
            end
            S_EUC_UPD:
            begin
                t0_next    = t1_reg;
                t1_next    = am_out;
                r0_next    = r1_reg;
                r1_next    = div_rem;
                state_next = S_EUC_CHK;
            end
            S_FIN:
            begin
                result_next = 32'(p_reg);
                noinv_next  = 1'b0;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_FIN;
            m_reg     <= W'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            m_reg     <= m_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        p_reg      <= p_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        cnt_reg    <= cnt_next;
        r0_reg     <= r0_next;
        r1_reg     <= r1_next;
        t0_reg     <= t0_next;
        t1_reg     <= t1_next;
        result_reg <= result_next;
        noinv_reg  <= noinv_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign result     = result_reg;
    assign no_inverse = noinv_reg;

    // result strobe only once the sequencer is back in idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");

    // a failed inverse always gives a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_inverse) |-> (result == 32'd0))
        else $error("no_inverse with non-zero result");

    // an accepted transaction makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("transaction not taken");

    // reduced results stay below a non-zero modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && m_reg != '0) |-> (p_reg < m_reg))
        else $error("result not reduced");

endmodule
